/* rtl/ivp_pkg.sv */
// shared types, register indexes and reset values for the input voltage monitor
package ivp_pkg;

  // supply mode codes
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ON      = 2'd1,
    MODE_REDUCED = 2'd2
  } ivp_mode_t;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_POWER_ON_LEVEL    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RESTORE_LEVEL     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFF_LEVEL         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REDUCE_LOW_LEVEL  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REDUCE_HIGH_LEVEL = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OFF_DELAY_MS      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STARTUP_WINDOW_MS = 3'd6;

  // register reset values
  localparam logic [11:0] RST_POWER_ON_LEVEL    = 12'd2200;
  localparam logic [11:0] RST_RESTORE_LEVEL     = 12'd2000;
  localparam logic [11:0] RST_OFF_LEVEL         = 12'd1600;
  localparam logic [11:0] RST_REDUCE_LOW_LEVEL  = 12'd1700;
  localparam logic [11:0] RST_REDUCE_HIGH_LEVEL = 12'd1900;
  localparam logic [15:0] RST_OFF_DELAY_MS      = 16'd3000;
  localparam logic [15:0] RST_STARTUP_WINDOW_MS = 16'd5000;

  // input word
  typedef struct packed {
    logic [11:0] voltage_sample;
    logic [31:0] now_ms;
  } ivp_in_t;

  // result word
  typedef struct packed {
    logic [1:0] supply_mode;
    logic       power_down_flag;
    logic       startup_flag;
  } ivp_out_t;

  // configuration register set
  typedef struct packed {
    logic [11:0] power_on_level;
    logic [11:0] restore_level;
    logic [11:0] off_level;
    logic [11:0] reduce_low_level;
    logic [11:0] reduce_high_level;
    logic [15:0] off_delay_ms;
    logic [15:0] startup_window_ms;
  } ivp_cfg_t;

  // monitor state carried from word to word
  typedef struct packed {
    ivp_mode_t   mode;
    logic        window_passed;
    logic [31:0] last_transition_ms;
    logic        delay_done;
    logic        first_sample;
    logic        reduced_flag;
    logic        startup_flag;
  } ivp_state_t;

endpackage

/* rtl/ivp_cfg_regs.sv */
// configuration registers of the input voltage monitor
module ivp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ivp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ivp_pkg::CfgDataW-1:0]  cfg_data,
  output ivp_pkg::ivp_cfg_t             cfg
);

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_on_level    <= ivp_pkg::RST_POWER_ON_LEVEL;
      cfg.restore_level     <= ivp_pkg::RST_RESTORE_LEVEL;
      cfg.off_level         <= ivp_pkg::RST_OFF_LEVEL;
      cfg.reduce_low_level  <= ivp_pkg::RST_REDUCE_LOW_LEVEL;
      cfg.reduce_high_level <= ivp_pkg::RST_REDUCE_HIGH_LEVEL;
      cfg.off_delay_ms      <= ivp_pkg::RST_OFF_DELAY_MS;
      cfg.startup_window_ms <= ivp_pkg::RST_STARTUP_WINDOW_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        ivp_pkg::REG_POWER_ON_LEVEL:    cfg.power_on_level    <= cfg_data[11:0];
        ivp_pkg::REG_RESTORE_LEVEL:     cfg.restore_level     <= cfg_data[11:0];
        ivp_pkg::REG_OFF_LEVEL:         cfg.off_level         <= cfg_data[11:0];
        ivp_pkg::REG_REDUCE_LOW_LEVEL:  cfg.reduce_low_level  <= cfg_data[11:0];
        ivp_pkg::REG_REDUCE_HIGH_LEVEL: cfg.reduce_high_level <= cfg_data[11:0];
        ivp_pkg::REG_OFF_DELAY_MS:      cfg.off_delay_ms      <= cfg_data;
        ivp_pkg::REG_STARTUP_WINDOW_MS: cfg.startup_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ivp_step.sv */
// single-word step of the supply monitor: next state and result from current state
module ivp_step (
  input  ivp_pkg::ivp_state_t state,
  input  ivp_pkg::ivp_cfg_t   cfg,
  input  ivp_pkg::ivp_in_t    in_word,
  output ivp_pkg::ivp_state_t state_next,
  output ivp_pkg::ivp_out_t   result
);

  logic [11:0] v;
  logic [31:0] now;
  logic [31:0] elapsed;
  logic [31:0] base_ms;
  logic        base_done;
  logic        window_now;
  logic        delay_hit;

  // elapsed time and first-sample fix-up
  always_comb begin
    v          = in_word.voltage_sample;
    now        = in_word.now_ms;
    elapsed    = now - state.last_transition_ms;
    base_ms    = state.first_sample ? now : state.last_transition_ms;
    base_done  = state.first_sample ? 1'b1 : state.delay_done;
    window_now = state.window_passed || (elapsed >= {16'd0, cfg.startup_window_ms});
    delay_hit  = elapsed >= {16'd0, cfg.off_delay_ms};
  end

  // next mode, window, transition time and delay state
  // flags follow the mode held before the step
  always_comb begin
    state_next.mode               = state.mode;
    state_next.window_passed      = window_now;
    state_next.last_transition_ms = base_ms;
    state_next.delay_done         = base_done;
    state_next.first_sample       = 1'b0;
    state_next.reduced_flag       = state.reduced_flag;
    state_next.startup_flag       = state.startup_flag;
    case (state.mode)
      ivp_pkg::MODE_ON: begin
        state_next.reduced_flag = 1'b0;
        state_next.startup_flag = 1'b1;
        if (v < cfg.off_level) begin
          state_next.window_passed      = 1'b1;
          state_next.mode               = ivp_pkg::MODE_OFF;
          state_next.last_transition_ms = now;
          state_next.delay_done         = 1'b0;
        end else if (v > cfg.reduce_low_level && v < cfg.reduce_high_level) begin
          state_next.mode               = ivp_pkg::MODE_REDUCED;
          state_next.last_transition_ms = now;
        end
      end
      ivp_pkg::MODE_REDUCED: begin
        state_next.reduced_flag = 1'b1;
        if (v > cfg.restore_level) begin
          state_next.mode               = ivp_pkg::MODE_ON;
          state_next.last_transition_ms = now;
        end else if (v < cfg.off_level) begin
          state_next.mode               = ivp_pkg::MODE_OFF;
          state_next.last_transition_ms = now;
          state_next.delay_done         = 1'b0;
        end
      end
      default: begin
        // off, and any unused code treated as off
        state_next.mode = ivp_pkg::MODE_OFF;
        if (!base_done) begin
          if (delay_hit) begin
            state_next.delay_done   = 1'b1;
            state_next.startup_flag = 1'b0;
          end
          if (v > cfg.restore_level) begin
            state_next.mode               = ivp_pkg::MODE_ON;
            state_next.last_transition_ms = now;
          end
        end else if ((!window_now && v > cfg.power_on_level) ||
                     (window_now && v > cfg.restore_level)) begin
          state_next.mode               = ivp_pkg::MODE_ON;
          state_next.last_transition_ms = now;
          state_next.delay_done         = 1'b0;
        end
      end
    endcase
  end

  // result word
  always_comb begin
    result.supply_mode     = state_next.mode;
    result.power_down_flag = state_next.reduced_flag;
    result.startup_flag    = state_next.startup_flag;
  end

endmodule

/* rtl/input_voltage_protection_fsm.sv */
// Input voltage protection monitor: off / on / reduced power with hysteresis.
// Pipeline: two register stages (input register, then result register); a word
// waits in the input register while the result side stalls.
// Throughput: one word per cycle while the result side does not stall.
// Reset (synchronous, active high): mode off, startup flag set, delay done,
// first sample pending, thresholds back to their default values.
module input_voltage_protection_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ivp_pkg::ivp_in_t              in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ivp_pkg::ivp_out_t             out_word,
  input  logic                          cfg_we,
  input  logic [ivp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ivp_pkg::CfgDataW-1:0]  cfg_data
);

  ivp_pkg::ivp_cfg_t   cfg;
  ivp_pkg::ivp_state_t state;
  ivp_pkg::ivp_state_t state_next;
  ivp_pkg::ivp_in_t    hold_word;
  ivp_pkg::ivp_out_t   result;
  logic                hold_valid;
  logic                out_free;
  logic                step_fire;

  ivp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ivp_step u_step (
    .state      (state),
    .cfg        (cfg),
    .in_word    (hold_word),
    .state_next (state_next),
    .result     (result)
  );

  // handshake between the two register stages
  assign out_free  = !out_valid || !out_stall;
  assign step_fire = hold_valid && out_free;
  assign in_stall  = hold_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_word <= in_word;
    end
  end

  // monitor state advances once per word stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode               <= ivp_pkg::MODE_OFF;
      state.window_passed      <= 1'b0;
      state.last_transition_ms <= 32'd0;
      state.delay_done         <= 1'b1;
      state.first_sample       <= 1'b1;
      state.reduced_flag       <= 1'b0;
      state.startup_flag       <= 1'b1;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_word <= result;
    end
  end

endmodule
